[sv/bounded_substring_search_defines.svh]
// Assertion macros shared by the search block.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef BOUNDED_SUBSTRING_SEARCH_DEFINES_SVH
`define BOUNDED_SUBSTRING_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define BSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bss: same-cycle check failed");
`define BSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bss: next-cycle check failed");
`else
`define BSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/bss_pkg.sv]
`default_nettype none

package bss_pkg;

  localparam int unsigned PATTERN_BYTES_DEF = 128;
  localparam int unsigned BUFFER_BYTES_DEF  = 4096;

  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LENGTH_W = 8;
  localparam int unsigned OFFSET_W = 12;

  // Item kinds carried in tuser on the input side
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_DATA    = 1'b1;

  // Pattern store write request
  typedef struct packed {
    logic               we;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;
  } bss_pat_wr_t;

  // Window push request
  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
  } bss_push_t;

endpackage

`default_nettype wire

[sv/bss_pattern.sv]
`default_nettype none

module bss_pattern
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire bss_pat_wr_t                       wr_i,
  output logic        [PATTERN_BYTES*BYTE_W-1:0] pattern_o
);

  logic [PATTERN_BYTES*BYTE_W-1:0] pat_q;

  // Decode per entry; indexes at or above the store depth match no entry and drop.
  for (genvar e = 0; e < PATTERN_BYTES; e++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (wr_i.we && (9'(wr_i.index) == 9'(e))) begin
        pat_q[e*BYTE_W +: BYTE_W] <= wr_i.data;
      end
    end
  end

  assign pattern_o = pat_q;

endmodule

`default_nettype wire

[sv/bss_window.sv]
`default_nettype none

module bss_window
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF,
  localparam int unsigned LW = $clog2(PATTERN_BYTES + 1)
) (
  input  wire logic                              clk_i,
  input  wire bss_push_t                         push_i,
  input  wire logic        [LW-1:0]              len_i,
  input  wire logic        [PATTERN_BYTES*BYTE_W-1:0] pattern_i,
  output logic                                   match_o
);

  localparam int unsigned WW = PATTERN_BYTES * BYTE_W;

  logic [WW-1:0]           window_q;
  logic [WW-1:0]           window_d;
  logic [WW-1:0]           aligned;
  logic [LW-1:0]           shift;
  logic [PATTERN_BYTES-1:0] lane_ok;

  // Newest byte enters at the top; the oldest drops off the bottom.
  if (PATTERN_BYTES == 1) begin : g_one
    assign window_d = push_i.data;
  end else begin : g_many
    assign window_d = {push_i.data, window_q[WW-1:BYTE_W]};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      window_q <= window_d;
    end
  end

  // Bring the newest len bytes down to lane 0, oldest first.
  assign shift   = LW'(PATTERN_BYTES) - len_i;
  assign aligned = window_d >> {shift, 3'b000};

  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_lane
    assign lane_ok[j] = ({1'b0, len_i} <= (LW+1)'(j)) ||
                        (aligned[j*BYTE_W +: BYTE_W] == pattern_i[j*BYTE_W +: BYTE_W]);
  end

  assign match_o = &lane_ok;

endmodule

`default_nettype wire

[sv/bounded_substring_search.sv]
`default_nettype none
// Streaming first-match search of a stored byte pattern in byte buffers. Each input
// transaction either writes one pattern byte (tuser = 0, index in tdata[6:0], byte in
// tdata[14:7]) or carries one buffer byte (tuser = 1, tlast on the final byte). The
// pattern length is a separate register, to be written by the user only while the block
// is idle; the block itself does not enforce this. Lengths above PATTERN_BYTES count as
// PATTERN_BYTES. Every buffer yields exactly one output transaction: tuser = 1 with the
// start offset of the first match (saturated at BUFFER_BYTES - 1), or tuser = 0 with
// offset 0 at the buffer's last byte. Bytes after a match are dropped until tlast. An
// empty pattern matches at offset 0 on the first byte. The block takes one transaction
// per cycle while the result register is not stalled; a result passes through the input
// register and then the result register, and a stalled result holds the input register.
// The clock figure is set by the combinational window compare: a byte-granular barrel shift
// of the PATTERN_BYTES-byte window followed by a PATTERN_BYTES-lane equality and AND reduction.
// Pattern bytes reset to unknown and must be written before use; no clearing pass is needed.

`include "bounded_substring_search_defines.svh"

module bounded_substring_search
  import bss_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int unsigned BUFFER_BYTES  = BUFFER_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Pattern length register
  input  wire logic                cfg_we_i,
  input  wire logic [LENGTH_W-1:0] cfg_wdata_i,
  // Input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [15:0]         s_axis_tdata,   // [6:0] pattern_index, [14:7] value, [15] zero
  input  wire logic                s_axis_tuser,   // [0] kind
  input  wire logic                s_axis_tlast,
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata,   // [11:0] match_offset, [15:12] zero
  output logic                     m_axis_tuser    // [0] found
);

  localparam int unsigned LW = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned SW = $clog2(BUFFER_BYTES + PATTERN_BYTES + 1);
  localparam logic [SW-1:0] SEEN_MAX = SW'(BUFFER_BYTES + PATTERN_BYTES);
  localparam logic [SW-1:0] OFF_MAX  = SW'(BUFFER_BYTES - 1);

  // Configuration
  logic [LENGTH_W-1:0] cfg_len_q;
  logic [LW-1:0]       len;

  // Input register
  logic                in_valid_q;
  logic                in_kind_q;
  logic [INDEX_W-1:0]  in_index_q;
  logic [BYTE_W-1:0]   in_value_q;
  logic                in_last_q;

  // Buffer state
  logic [SW-1:0]       seen_q, seen_d, seen_inc;
  logic                reported_q, reported_d;

  // Result register
  logic                res_valid_q;
  logic                res_found_q;
  logic [OFFSET_W-1:0] res_off_q;

  logic                advance, fire, data_fire, search, hit, emit, win_match;
  logic [SW-1:0]       diff, offset;
  logic [PATTERN_BYTES*BYTE_W-1:0] pattern;
  bss_pat_wr_t         pat_wr;
  bss_push_t           push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= '0;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  // Clamp the length to the store depth.
  always_comb begin
    if (9'(cfg_len_q) > 9'(PATTERN_BYTES)) begin
      len = LW'(PATTERN_BYTES);
    end else begin
      len = LW'(cfg_len_q);
    end
  end

  // Hold the input register while the result register is full and stalled.
  assign advance       = !res_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q  <= s_axis_tuser;
      in_index_q <= s_axis_tdata[6:0];
      in_value_q <= s_axis_tdata[14:7];
      in_last_q  <= s_axis_tlast;
    end
  end

  assign pat_wr.we    = fire && (in_kind_q == KIND_PATTERN);
  assign pat_wr.index = in_index_q;
  assign pat_wr.data  = in_value_q;

  bss_pattern #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_pattern (
    .clk_i     (clk_i),
    .wr_i      (pat_wr),
    .pattern_o (pattern)
  );

  // Buffer bytes after a reported match never enter the window.
  assign data_fire = fire && (in_kind_q == KIND_DATA);
  assign search    = data_fire && !reported_q;

  assign push.push = search;
  assign push.data = in_value_q;

  bss_window #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_window (
    .clk_i     (clk_i),
    .push_i    (push),
    .len_i     (len),
    .pattern_i (pattern),
    .match_o   (win_match)
  );

  assign seen_inc = (seen_q < SEEN_MAX) ? seen_q + 1'b1 : seen_q;

  // A match counts only once the window holds len bytes of this buffer.
  assign hit  = search && ((len == '0) || ((seen_inc >= SW'(len)) && win_match));
  assign emit = hit || (search && in_last_q);

  assign diff = seen_inc - SW'(len);
  always_comb begin
    if (len == '0) begin
      offset = '0;
    end else if (diff > OFF_MAX) begin
      offset = OFF_MAX;
    end else begin
      offset = diff;
    end
  end

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (data_fire) begin
      if (in_last_q) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end else if (!reported_q) begin
        seen_d     = seen_inc;
        reported_d = hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // Result register: load on a result, drop once the downstream takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire && emit) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_found_q <= hit;
      res_off_q   <= hit ? OFFSET_W'(offset) : '0;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_found_q;
  assign m_axis_tdata  = {4'b0000, res_off_q};

  `BSS_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, res_valid_q && !m_axis_tready, !fire)
  `BSS_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, res_valid_q && !res_found_q, res_off_q == '0)
  `BSS_ASSERT_NXT(a_hit_mutes, clk_i, rst_ni, hit && !in_last_q, reported_q)
  `BSS_ASSERT_IMP(a_seen_bound, clk_i, rst_ni, in_valid_q, seen_q <= SEEN_MAX)
  `BSS_ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(res_valid_q), $past(fire && emit))

endmodule

`default_nettype wire

[test/bss_result_checker.sv]
`timescale 1ns / 1ps

module bss_result_checker
  import bss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LENGTH_W-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [6:0] pattern_index, [14:7] value, [15] zero
  input  logic                s_axis_tuser,   // [0] kind
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,   // [11:0] match_offset, [15:12] zero
  input  logic                m_axis_tuser,   // [0] found
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned WIN      = PATTERN_BYTES_DEF;
  localparam int unsigned SEEN_CAP = BUFFER_BYTES_DEF + PATTERN_BYTES_DEF;
  localparam int unsigned OFF_CAP  = BUFFER_BYTES_DEF - 1;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } search_result_t;

  logic [BYTE_W-1:0]   pattern_mem [WIN];
  logic [BYTE_W-1:0]   window_mem  [WIN];
  int unsigned         win_head;
  int unsigned         buf_seen;
  logic                buf_done;
  logic [LENGTH_W-1:0] pat_len;
  search_result_t      expected_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic clear_search();
    int i;
    for (i = 0; i < WIN; i++) begin
      pattern_mem[i] = '0;
      window_mem[i]  = '0;
    end
    win_head = 0;
    buf_seen = 0;
    buf_done = 1'b0;
    pat_len  = '0;
    expected_results.delete();
  endtask

  task automatic note_failure(input string what, input search_result_t want,
                              input search_result_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t: %s: expected found=%0b offset=%0d, got found=%0b offset=%0d",
               $realtime, what, want.found, want.offset, got.found, got.offset);
  endtask

  // Advance the search by one input transaction and queue the result it causes.
  task automatic search_step(input logic kind, input logic [INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic last);
    int unsigned    eff;
    int unsigned    off;
    int unsigned    j;
    logic           hit;
    search_result_t res;
    if (kind == KIND_PATTERN) begin
      pattern_mem[idx] = val;
    end else if (buf_done) begin
      if (last) begin
        buf_seen = 0;
        buf_done = 1'b0;
      end
    end else begin
      window_mem[win_head] = val;
      win_head = (win_head + 1) % WIN;
      if (buf_seen < SEEN_CAP) buf_seen++;
      eff = (pat_len > WIN) ? WIN : pat_len;
      hit = 1'b0;
      off = 0;
      if (eff == 0) begin
        hit = 1'b1;
      end else if (buf_seen >= eff) begin
        hit = 1'b1;
        for (j = 0; j < eff; j++)
          if (window_mem[(win_head + WIN - eff + j) % WIN] !== pattern_mem[j]) hit = 1'b0;
        off = buf_seen - eff;
        if (off > OFF_CAP) off = OFF_CAP;
      end
      if (hit || last) begin
        res.found  = hit;
        res.offset = hit ? OFFSET_W'(off) : '0;
        expected_results.push_back(res);
        if (last) begin
          buf_seen = 0;
          buf_done = 1'b0;
        end else begin
          buf_done = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t got;
    search_result_t want;
    if (!rst_ni) begin
      clear_search();
    end else begin
      if (cfg_we_i) pat_len = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        search_step(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[14:7], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.found  = m_axis_tuser;
        got.offset = m_axis_tdata[OFFSET_W-1:0];
        if (expected_results.size() == 0) begin
          note_failure("result with nothing expected", got, got);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.offset !== want.offset)
            note_failure("result mismatch", want, got);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

[test/tb_bounded_substring_search.sv]
`timescale 1ns / 1ps

module tb_bounded_substring_search;
  import bss_pkg::*;

  localparam int unsigned WIN          = PATTERN_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1650;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LENGTH_W-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // [6:0] pattern_index, [14:7] value, [15] zero
  logic                s_axis_tuser;   // [0] kind
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [11:0] match_offset, [15:12] zero
  logic                m_axis_tuser;   // [0] found

  int fail_count;
  int pending;

  // Idle percentages of the two sides; the phases below change them
  int src_idle_pct;
  int dst_idle_pct;
  int items_sent;

  // Shadow of the pattern bytes, used only to shape the buffers so that matches occur
  logic [BYTE_W-1:0] pat_copy    [WIN];
  bit                pat_written [WIN];
  int unsigned       cur_len;    // effective pattern length, capped at the store depth

  bounded_substring_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bss_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legitimate run
  initial begin
    #2000000;
    $display("** bounded_substring_search: FAILED **");
    $finish;
  end

  // Receiver back-pressure: redraw tready once per cycle, at the falling edge only
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

  // Offer one transaction and hold it until taken. Any idle gap lowers tvalid in its
  // own cycle, so tvalid is never dropped and raised within the same time step.
  task automatic push_item(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [BYTE_W-1:0] val, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, val, idx};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Pattern writes carry a random tlast, which the block must ignore
  task automatic write_pattern(input int unsigned idx, input logic [BYTE_W-1:0] val);
    push_item(KIND_PATTERN, INDEX_W'(idx), val, 1'($urandom_range(1)));
    pat_copy[idx]    = val;
    pat_written[idx] = 1'b1;
  endtask

  // Drop tvalid, drain every outstanding result, then allow with margin for bytes still
  // in flight that cause no result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write the length register while idle. Fill any pattern entry the new length would
  // compare before it has ever been written.
  task automatic set_length(input int unsigned len);
    int unsigned eff;
    int unsigned i;
    eff = (len > WIN) ? WIN : len;
    for (i = 0; i < eff; i++)
      if (!pat_written[i]) write_pattern(i, BYTE_W'($urandom_range(255)));
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LENGTH_W'(len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_len = eff;
  endtask

  // Send one buffer of n bytes. With plant_at >= 0 the current pattern is laid down
  // from that offset. Otherwise bytes are half drawn from the pattern, so partial
  // matches and matches straddling buffers occur. A quiet buffer never starts a match
  // on its filler and takes no pattern writes mid-buffer.
  task automatic send_buffer(input int n, input int plant_at, input bit quiet);
    int                i;
    logic [BYTE_W-1:0] b;
    for (i = 0; i < n; i++) begin
      if (!quiet && $urandom_range(99) < 4)
        write_pattern($urandom_range(WIN - 1), BYTE_W'($urandom_range(255)));
      if (plant_at >= 0 && i >= plant_at && i < plant_at + int'(cur_len)) begin
        b = pat_copy[i - plant_at];
      end else if (quiet) begin
        b = BYTE_W'($urandom_range(255));
        if (b == pat_copy[0]) b = ~b;
      end else if (cur_len > 0 && $urandom_range(1) == 1) begin
        b = pat_copy[$urandom_range(cur_len - 1)];
      end else begin
        b = BYTE_W'($urandom_range(255));
      end
      push_item(KIND_DATA, INDEX_W'($urandom_range(WIN - 1)), b, i == n - 1);
    end
  endtask

  // Mostly short patterns, now and then empty, full depth or beyond it
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 88) return $urandom_range(7, 24);
    if (r < 92) return WIN;
    if (r < 95) return $urandom_range(WIN + 1, 255);
    return $urandom_range(25, WIN - 1);
  endfunction

  initial begin
    int          phase;
    int          phase_end;
    int          nbuf;
    int          n;
    int          plant_at;
    bit          first_seg;
    int unsigned forced_len [3];

    forced_len[0] = WIN;
    forced_len[1] = 255;
    forced_len[2] = 0;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_PATTERN;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    items_sent    = 0;
    cur_len       = 0;
    src_idle_pct  = 38;
    dst_idle_pct  = 73;
    for (int i = 0; i < WIN; i++) begin
      pat_copy[i]    = '0;
      pat_written[i] = 1'b0;
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty pattern straight after reset: the first byte matches at offset 0, the
    // rest of that buffer is dropped, and a one-byte buffer matches on its tlast byte.
    push_item(KIND_DATA, 7'd0,   8'h00, 1'b0);
    push_item(KIND_DATA, 7'd127, 8'hFF, 1'b1);
    push_item(KIND_DATA, 7'd0,   8'h00, 1'b1);

    // Pattern 00 FF 00, with zero bytes inside it
    write_pattern(0, 8'h00);
    write_pattern(1, 8'hFF);
    write_pattern(2, 8'h00);
    write_pattern(127, 8'hA5);
    set_length(3);

    // Match ending on the tlast byte, at offset 1
    push_item(KIND_DATA, 7'd0, 8'hFF, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'hFF, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b1);
    // Buffer shorter than the pattern: not found
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'hFF, 1'b1);
    // Match at offset 0 mid-buffer; the trailing bytes and their tlast give nothing
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'hFF, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'h55, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'hAA, 1'b1);
    // Pattern rewritten mid-buffer takes effect at once
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b0);
    write_pattern(1, 8'h55);
    push_item(KIND_DATA, 7'd0, 8'h55, 1'b0);
    push_item(KIND_DATA, 7'd0, 8'h00, 1'b1);

    // Random buffers in three idling phases, each opening on an extreme length
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 38;
          dst_idle_pct = 73;
        end
        1: begin
          src_idle_pct = 73;
          dst_idle_pct = 38;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      phase_end = items_sent + RANDOM_ITEMS / 3;
      first_seg = 1'b1;
      while (items_sent < phase_end) begin
        set_length(first_seg ? forced_len[phase] : pick_length());
        first_seg = 1'b0;
        nbuf = (cur_len > 24) ? 2 : $urandom_range(3, 8);
        repeat (nbuf) begin
          if (cur_len > 24) n = $urandom_range(cur_len - cur_len / 4, cur_len + 10);
          else              n = $urandom_range(1, cur_len + 10);
          plant_at = -1;
          if (n >= int'(cur_len) && $urandom_range(99) < 60)
            plant_at = $urandom_range(n - cur_len);
          send_buffer(n, plant_at, 1'b0);
        end
      end
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** bounded_substring_search: PASSED **");
    end else begin
      $display("** bounded_substring_search: FAILED **");
    end
    $finish;
  end

endmodule
